/* src/console_scrollback_buffer_macros.svh */
// Assertion macros used by the console scrollback buffer datapath.
`ifndef CONSOLE_SCROLLBACK_BUFFER_MACROS_SVH
`define CONSOLE_SCROLLBACK_BUFFER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CSB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("csb assertion failed");
`define CSB_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("csb assertion failed");
`else
`define CSB_ASSERT(name, clk, rst, prop)
`define CSB_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

/* src/csb_pkg.sv */
// Types and constants of the console scrollback buffer.
`default_nettype none
package csb_pkg;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] char_code;
      logic [7:0] ink_color;
      logic [7:0] read_line;
      logic [6:0] read_column;
   } req_type;

   typedef struct packed {
      logic [8:0] held_count;
      logic [7:0] current_length;
      logic [7:0] cell_char;
      logic [7:0] cell_color;
      logic [7:0] read_length;
      logic       read_valid;
   } rsp_type;

   typedef struct packed {
      logic put;
      logic clear;
      logic zero_read;
      logic read_start;
      logic read_finish;
   } cmd_type;

endpackage
`default_nettype wire

/* src/csb_ctrl.sv */
// Request sequencing state machine of the console scrollback buffer.
`default_nettype none
module csb_ctrl
   import csb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] operation,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      cmd             = '0;
      cmd.put         = accept && (operation == OP_PUT);
      cmd.clear       = accept && (operation == OP_CLEAR);
      cmd.read_start  = accept && (operation == OP_READ);
      cmd.zero_read   = accept && (operation != OP_READ);
      cmd.read_finish = (state_ff == S_READ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (operation == OP_READ) begin
                     state_ff <= S_READ;
                  end else begin
                     state_ff     <= S_RESP;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_READ: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* src/csb_datapath.sv */
// Line ring, text stores and response registers of the console scrollback buffer.
`default_nettype none
`include "console_scrollback_buffer_macros.svh"
module csb_datapath
   import csb_pkg::*;
#(
   parameter int LINE_SLOTS = 256,
   parameter int LINE_CHARS = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   output rsp_type      rsp_data
);

   localparam int SW = $clog2(LINE_SLOTS);
   localparam int CW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
   localparam int HW = $clog2(LINE_SLOTS + 1);
   localparam int RW = (HW > 8) ? HW : 8;
   localparam int AW = RW + 1;
   localparam int CELLS = 1 << (SW + CW);
   localparam logic [SW-1:0] LAST_SLOT = SW'(LINE_SLOTS - 1);
   localparam logic [HW-1:0] SLOTS_H   = HW'(LINE_SLOTS);
   localparam logic [7:0]    FULL_LEN  = 8'(LINE_CHARS);

   logic [SW-1:0] oldest_ff, oldest_in;
   logic [SW-1:0] newest_ff, newest_in;
   logic [HW-1:0] held_ff, held_in;
   logic [7:0]    cur_len_ff, cur_len_in;

   logic [7:0] len_mem   [LINE_SLOTS];
   logic [7:0] char_mem  [CELLS];
   logic [7:0] color_mem [CELLS];

   logic [7:0] len_q, char_q, color_q;
   logic       hit_ff, newest_hit_ff;
   logic [6:0] rcol_ff;

   logic [7:0] rsp_len_ff, rsp_char_ff, rsp_color_ff;
   logic       rsp_rvalid_ff;

   logic          is_nl, is_bs, open_line, full, char_we;
   logic [SW-1:0] newest_inc, oldest_inc, wr_slot;
   logic [CW-1:0] wr_col, rd_col;
   logic [AW-1:0] rd_sum;
   logic [SW-1:0] rd_slot;
   logic          rd_hit, rd_newest;
   logic [7:0]    fin_len;
   logic          fin_valid;
   logic [HW:0]   ring_sum, ring_slot;

   assign is_nl      = (req_data.char_code == CH_NEWLINE);
   assign is_bs      = (req_data.char_code == CH_BACKSPACE);
   assign open_line  = is_nl || (!is_bs && (cur_len_ff == FULL_LEN));
   assign full       = (held_ff == SLOTS_H);
   assign newest_inc = (newest_ff == LAST_SLOT) ? '0 : newest_ff + SW'(1);
   assign oldest_inc = (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + SW'(1);
   assign char_we    = cmd.put && !is_nl && !is_bs;
   assign wr_slot    = open_line ? newest_inc : newest_ff;
   assign wr_col     = open_line ? '0 : cur_len_ff[CW-1:0];

   always_comb begin
      oldest_in  = oldest_ff;
      newest_in  = newest_ff;
      held_in    = held_ff;
      cur_len_in = cur_len_ff;
      if (cmd.clear) begin
         oldest_in  = '0;
         newest_in  = '0;
         held_in    = HW'(1);
         cur_len_in = '0;
      end else if (cmd.put) begin
         if (open_line) begin
            newest_in = newest_inc;
            if (full) begin
               oldest_in = oldest_inc;
            end else begin
               held_in = held_ff + HW'(1);
            end
         end
         if (is_nl) begin
            cur_len_in = '0;
         end else if (is_bs) begin
            if (cur_len_ff != 8'd0) begin
               cur_len_in = cur_len_ff - 8'd1;
            end
         end else begin
            cur_len_in = (open_line ? 8'd0 : cur_len_ff) + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff  <= '0;
         newest_ff  <= '0;
         held_ff    <= HW'(1);
         cur_len_ff <= '0;
      end else begin
         oldest_ff  <= oldest_in;
         newest_ff  <= newest_in;
         held_ff    <= held_in;
         cur_len_ff <= cur_len_in;
      end
   end

   // read addressing: logical line to ring slot
   assign rd_hit    = RW'(req_data.read_line) < RW'(held_ff);
   assign rd_newest = RW'(req_data.read_line) == (RW'(held_ff) - RW'(1));
   assign rd_sum    = AW'(oldest_ff) + AW'(req_data.read_line);
   assign rd_slot   = (rd_sum >= AW'(LINE_SLOTS)) ? SW'(rd_sum - AW'(LINE_SLOTS))
                                                  : SW'(rd_sum);
   assign rd_col    = CW'({1'b0, req_data.read_column});

   always_ff @(posedge clock) begin
      if (cmd.put && open_line) begin
         len_mem[newest_ff] <= cur_len_ff;
      end
      if (cmd.read_start) begin
         len_q <= len_mem[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem[{wr_slot, wr_col}]  <= req_data.char_code;
         color_mem[{wr_slot, wr_col}] <= req_data.ink_color;
      end
      if (cmd.read_start) begin
         char_q  <= char_mem[{rd_slot, rd_col}];
         color_q <= color_mem[{rd_slot, rd_col}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_start) begin
         hit_ff        <= rd_hit;
         newest_hit_ff <= rd_newest;
         rcol_ff       <= req_data.read_column;
      end
   end

   assign fin_len   = !hit_ff ? 8'd0 : (newest_hit_ff ? cur_len_ff : len_q);
   assign fin_valid = hit_ff && ({1'b0, rcol_ff} < fin_len);

   always_ff @(posedge clock) begin
      if (cmd.zero_read) begin
         rsp_len_ff    <= '0;
         rsp_rvalid_ff <= 1'b0;
         rsp_char_ff   <= '0;
         rsp_color_ff  <= '0;
      end else if (cmd.read_finish) begin
         rsp_len_ff    <= fin_len;
         rsp_rvalid_ff <= fin_valid;
         rsp_char_ff   <= fin_valid ? char_q : 8'd0;
         rsp_color_ff  <= fin_valid ? color_q : 8'd0;
      end
   end

   always_comb begin
      rsp_data                = '0;
      rsp_data.held_count     = 9'(held_ff);
      rsp_data.current_length = cur_len_ff;
      rsp_data.cell_char      = rsp_char_ff;
      rsp_data.cell_color     = rsp_color_ff;
      rsp_data.read_length    = rsp_len_ff;
      rsp_data.read_valid     = rsp_rvalid_ff;
   end

   // newest slot must track oldest + held - 1 around the ring
   assign ring_sum  = (HW + 1)'(oldest_ff) + (HW + 1)'(held_ff) - (HW + 1)'(1);
   assign ring_slot = (ring_sum >= (HW + 1)'(LINE_SLOTS)) ?
                      ring_sum - (HW + 1)'(LINE_SLOTS) : ring_sum;

   `CSB_ASSERT(a_ring_newest, clock, reset, newest_ff == SW'(ring_slot))
   `CSB_ASSERT_NEXT(a_clear_state, clock, reset, cmd.clear,
      held_ff == HW'(1) && oldest_ff == '0 && cur_len_ff == 8'd0)
   `CSB_ASSERT_NEXT(a_newline_grow, clock, reset, cmd.put && is_nl && !full,
      held_ff == $past(held_ff) + HW'(1) && cur_len_ff == 8'd0)

endmodule
`default_nettype wire

/* src/console_scrollback_buffer.sv */
// Top level of the console scrollback buffer.
// Scrollback store for a text console: LINE_SLOTS lines of up to LINE_CHARS
// characters, each with a color, kept in a ring so the oldest line drops off
// when every slot is in use. One request is handled at a time. A put, clear or
// unused code gives its response in the cycle after acceptance; a read goes
// through S_READ before S_RESP, a state needed for the registered read port of
// the line-length and cell memories. The next request is taken in the cycle
// after the response is delivered. No clearing pass is needed after reset.
`default_nettype none
module console_scrollback_buffer
   import csb_pkg::*;
#(
   parameter int LINE_SLOTS = 256,
   parameter int LINE_CHARS = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type cmd;

   csb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .operation (req_data.operation),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   csb_datapath #(
      .LINE_SLOTS (LINE_SLOTS),
      .LINE_CHARS (LINE_CHARS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

/* dv/console_scrollback_buffer_tb.sv */
// Self-checking testbench for the console scrollback buffer.
module console_scrollback_buffer_tb;
   import csb_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int SLOTS = 256;
   localparam int COLS = 128;
   localparam int OPENING_ROWS = 25;
   localparam int PHASE_ITEMS = 400;
   localparam int MAX_WAIT = 17;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 200;

   typedef enum {SCROLL, FILL, MIXED} mix_type;

   typedef struct packed {
      req_type req;
      logic    known;
      rsp_type want;
   } script_row_type;

   localparam script_row_type OPENING [OPENING_ROWS] = '{
      '{'{OP_READ, 8'h00, 8'h00, 8'd0, 7'd0}, 1'b1, '{9'd1, 8'd0, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_SPARE, 8'hFF, 8'hFF, 8'd255, 7'd127}, 1'b1,
        '{9'd1, 8'd0, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_PUT, CH_BACKSPACE, 8'hFF, 8'd0, 7'd0}, 1'b1,
        '{9'd1, 8'd0, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_PUT, 8'h41, 8'hFF, 8'd0, 7'd0}, 1'b1, '{9'd1, 8'd1, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_PUT, 8'hFF, 8'h00, 8'd0, 7'd0}, 1'b1, '{9'd1, 8'd2, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_PUT, 8'h00, 8'hAA, 8'd0, 7'd0}, 1'b1, '{9'd1, 8'd3, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_PUT, 8'h7E, 8'h55, 8'd255, 7'd127}, 1'b0, '0},
      '{'{OP_READ, 8'h00, 8'h00, 8'd0, 7'd0}, 1'b1, '{9'd1, 8'd4, 8'h41, 8'hFF, 8'd4, 1'b1}},
      '{'{OP_READ, 8'h00, 8'h00, 8'd0, 7'd2}, 1'b1, '{9'd1, 8'd4, 8'h00, 8'hAA, 8'd4, 1'b1}},
      '{'{OP_READ, 8'h00, 8'h00, 8'd0, 7'd4}, 1'b1, '{9'd1, 8'd4, 8'h00, 8'h00, 8'd4, 1'b0}},
      '{'{OP_READ, 8'hFF, 8'hFF, 8'd0, 7'd127}, 1'b1,
        '{9'd1, 8'd4, 8'h00, 8'h00, 8'd4, 1'b0}},
      '{'{OP_READ, 8'h00, 8'h00, 8'd255, 7'd0}, 1'b1,
        '{9'd1, 8'd4, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_READ, 8'h00, 8'h00, 8'd1, 7'd0}, 1'b1, '{9'd1, 8'd4, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_PUT, CH_BACKSPACE, 8'h00, 8'd0, 7'd0}, 1'b1,
        '{9'd1, 8'd3, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_PUT, CH_NEWLINE, 8'h00, 8'd0, 7'd0}, 1'b1,
        '{9'd2, 8'd0, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_PUT, CH_BACKSPACE, 8'h00, 8'd0, 7'd0}, 1'b1,
        '{9'd2, 8'd0, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_READ, 8'h00, 8'h00, 8'd0, 7'd2}, 1'b1, '{9'd2, 8'd0, 8'h00, 8'hAA, 8'd3, 1'b1}},
      '{'{OP_READ, 8'h00, 8'h00, 8'd0, 7'd3}, 1'b1, '{9'd2, 8'd0, 8'h00, 8'h00, 8'd3, 1'b0}},
      '{'{OP_READ, 8'h00, 8'h00, 8'd1, 7'd0}, 1'b1, '{9'd2, 8'd0, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_PUT, 8'h09, 8'h80, 8'd0, 7'd0}, 1'b0, '0},
      '{'{OP_CLEAR, 8'hFF, 8'hFF, 8'd255, 7'd127}, 1'b1,
        '{9'd1, 8'd0, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_READ, 8'h00, 8'h00, 8'd0, 7'd0}, 1'b1, '{9'd1, 8'd0, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_READ, 8'h00, 8'h00, 8'd1, 7'd0}, 1'b1, '{9'd1, 8'd0, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_PUT, 8'h20, 8'h01, 8'd0, 7'd0}, 1'b1, '{9'd1, 8'd1, 8'h00, 8'h00, 8'd0, 1'b0}},
      '{'{OP_READ, 8'h00, 8'h00, 8'd0, 7'd0}, 1'b1, '{9'd1, 8'd1, 8'h20, 8'h01, 8'd1, 1'b1}}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // console image kept by the testbench
   logic [7:0] shown_char [SLOTS][COLS];
   logic [7:0] shown_ink [SLOTS][COLS];
   int         text_len [SLOTS];
   int         oldest_line = 0;
   int         lines_held = 1;

   rsp_type status_due [$];
   int      mismatch_total = 0;
   int      status_seen = 0;
   bit      steady_send = 1'b0;

   always #1 clock = ~clock;

   console_scrollback_buffer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   function automatic int slot_at(int n);
      return (oldest_line + n) % SLOTS;
   endfunction

   function void open_new_line();
      if (lines_held < SLOTS) lines_held++;
      else oldest_line = (oldest_line + 1) % SLOTS;
      text_len[slot_at(lines_held - 1)] = 0;
   endfunction

   function rsp_type console_apply(req_type r);
      rsp_type s;
      int      slot;
      s = '0;
      case (r.operation)
         OP_PUT: begin
            if (r.char_code == CH_NEWLINE) begin
               open_new_line();
            end else if (r.char_code == CH_BACKSPACE) begin
               slot = slot_at(lines_held - 1);
               if (text_len[slot] > 0) text_len[slot]--;
            end else begin
               if (text_len[slot_at(lines_held - 1)] >= COLS) open_new_line();
               slot = slot_at(lines_held - 1);
               shown_char[slot][text_len[slot]] = r.char_code;
               shown_ink[slot][text_len[slot]] = r.ink_color;
               text_len[slot]++;
            end
         end
         OP_CLEAR: begin
            oldest_line = 0;
            lines_held = 1;
            text_len[0] = 0;
         end
         OP_READ: begin
            if (int'(r.read_line) < lines_held) begin
               slot = slot_at(r.read_line);
               s.read_length = 8'(text_len[slot]);
               if (int'(r.read_column) < text_len[slot]) begin
                  s.read_valid = 1'b1;
                  s.cell_char = shown_char[slot][r.read_column];
                  s.cell_color = shown_ink[slot][r.read_column];
               end
            end
         end
         default: ;
      endcase
      s.held_count = 9'(lines_held);
      s.current_length = 8'(text_len[slot_at(lines_held - 1)]);
      return s;
   endfunction

   function automatic req_type random_request(mix_type mix);
      req_type r;
      int      pick;
      int      len;
      r.operation = OP_PUT;
      r.char_code = 8'($urandom_range(0, 255));
      r.ink_color = 8'($urandom_range(0, 255));
      r.read_line = 8'($urandom_range(0, 255));
      r.read_column = 7'($urandom_range(0, 127));
      pick = $urandom_range(0, 99);
      case (mix)
         SCROLL: begin
            if (pick < 65) r.char_code = CH_NEWLINE;
            else if (pick >= 88) r.operation = OP_READ;
            else if (pick >= 85) r.char_code = CH_BACKSPACE;
         end
         FILL: begin
            if (pick >= 78) r.operation = OP_READ;
            else if (pick >= 75) r.char_code = CH_NEWLINE;
            else if (pick >= 70) r.char_code = CH_BACKSPACE;
         end
         default: begin
            if (pick >= 63) r.operation = OP_READ;
            else if (pick >= 60) r.operation = OP_SPARE;
            else if (pick >= 58) r.operation = OP_CLEAR;
            else if (pick >= 52) r.char_code = CH_BACKSPACE;
            else if (pick >= 40) r.char_code = CH_NEWLINE;
         end
      endcase
      // aim most reads at held lines, and half of those at written columns
      if (r.operation == OP_READ && $urandom_range(0, 9) < 7) begin
         r.read_line = 8'($urandom_range(0, lines_held - 1));
         len = text_len[slot_at(r.read_line)];
         if (len > 0 && $urandom_range(0, 1) == 1) r.read_column = 7'($urandom_range(0, len - 1));
      end
      return r;
   endfunction

   task automatic offer(req_type r, logic known, rsp_type want);
      int      gap;
      rsp_type predicted;
      if ($urandom_range(0, 49) == 0) steady_send = !steady_send;
      gap = steady_send ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = console_apply(r);
      status_due.push_back(known ? want : predicted);
   endtask

   task automatic check_status(rsp_type got);
      rsp_type want;
      if (status_due.size() == 0) begin
         if (mismatch_total < 10) $display("unexpected response: %p", got);
         mismatch_total++;
      end else begin
         want = status_due.pop_front();
         if (got.held_count !== want.held_count || got.current_length !== want.current_length ||
             got.cell_char !== want.cell_char || got.cell_color !== want.cell_color ||
             got.read_length !== want.read_length || got.read_valid !== want.read_valid) begin
            if (mismatch_total < 10)
               $display("response %0d mismatch: expected %p, got %p", status_seen, want, got);
            mismatch_total++;
         end
      end
      status_seen++;
   endtask

   initial begin
      foreach (text_len[i]) text_len[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (OPENING[i]) offer(OPENING[i].req, OPENING[i].known, OPENING[i].want);
      for (int p = 0; p < 3; p++) begin
         for (int k = 0; k < PHASE_ITEMS; k++) offer(random_request(mix_type'(p)), 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("** console_scrollback_buffer: PASSED **");
      end else begin
         $display("** console_scrollback_buffer: FAILED **");
      end
      $finish;
   end

   // receiver; one long hold lets requests back up against the stall
   initial begin
      int wait_cycles;
      bit steady_take;
      steady_take = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) steady_take = !steady_take;
         wait_cycles = steady_take ? 0 : $urandom_range(0, MAX_WAIT);
         if (status_seen == HOLD_AT) wait_cycles = HOLD_CYCLES;
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         check_status(rsp_data);
      end
   end

   initial begin
      #1000000;
      $display("** console_scrollback_buffer: FAILED **");
      $finish;
   end

endmodule
